>>> hw/rtl/tbq_pkg.sv
// ----------------------------------------------------------------------------
// tbq_pkg: shared types and constants for the touch and button qualifier
// Holds the transfer payload structs, the configuration register map and
// the button action codes used by every file of the block.
// ----------------------------------------------------------------------------
package tbq_pkg;

  // Coordinate width of the touch controller.
  localparam int COORD_BITS = 12;

  // Configuration register map.
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 32;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE_HOLD = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_PRESS   = 2'd2;

  // Register values after reset, in microseconds.
  localparam logic [31:0] RELEASE_HOLD_RST = 32'd20000;
  localparam logic [31:0] DEBOUNCE_RST     = 32'd25000;
  localparam logic [31:0] LONG_PRESS_RST   = 32'd800000;

  // Touch read status codes.
  localparam logic [1:0] TS_NONE  = 2'd0;
  localparam logic [1:0] TS_POINT = 2'd1;

  // Button action codes.
  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_START  = 2'd1,
    ACT_STOP   = 2'd2,
    ACT_REPLAY = 2'd3
  } action_t;

  // One poll sample.
  typedef struct packed {
    logic [1:0]            touch_status;
    logic [COORD_BITS-1:0] touch_x;
    logic [COORD_BITS-1:0] touch_y;
    logic [31:0]           now_us;
    logic                  button_level;
    logic                  recording_active;
  } in_item_t;

  // One qualified result.
  typedef struct packed {
    logic                  touch_event;
    logic [COORD_BITS-1:0] event_x;
    logic [COORD_BITS-1:0] event_y;
    logic                  event_down;
    logic [31:0]           event_time_us;
    logic [1:0]            button_action;
  } out_item_t;

  // Touch event produced by the touch tracker.
  typedef struct packed {
    logic                  event_vld;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  down;
    logic [31:0]           time_us;
  } touch_evt_t;

  // Configuration register contents.
  typedef struct packed {
    logic [31:0] release_hold_us;
    logic [31:0] debounce_us;
    logic [31:0] long_press_us;
  } cfg_regs_t;

endpackage

>>> hw/rtl/touch_and_button_qualifier_unit.sv
// ----------------------------------------------------------------------------
// touch_and_button_qualifier_unit: touch and button poll qualifier
// Turns one poll sample per tick into one result: touch-down, move and
// touch-up events plus debounced button record and replay requests.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one poll sample per transfer; every
//   sample yields exactly one result on out_valid/out_ready/out_data.
//   cfg_we/cfg_index/cfg_wdata write the release hold, debounce and long
//   press times (indexes 0, 1, 2, microseconds); write them while idle.
//   The sample is taken into an input register, then one pass of compare
//   and subtract logic loads the result register and the state.
//   Throughput is one sample per cycle while the receiver does not stall;
//   the state feedback through that single pass sets the figure.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more sample; in_ready falls only when both
//   are full.
//   Synchronous active-low reset empties both registers, clears all touch
//   and button state and loads the register reset values.
// ----------------------------------------------------------------------------
module touch_and_button_qualifier_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tbq_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output tbq_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [tbq_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [tbq_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
  import tbq_pkg::*;

  cfg_regs_t  cfg_r;
  in_item_t   smp_r;
  logic       smp_vld_r;
  out_item_t  res_r;
  logic       res_vld_r;
  logic       step;
  touch_evt_t tevt;
  action_t    act;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.release_hold_us <= RELEASE_HOLD_RST;
      cfg_r.debounce_us     <= DEBOUNCE_RST;
      cfg_r.long_press_us   <= LONG_PRESS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RELEASE_HOLD: cfg_r.release_hold_us <= cfg_wdata;
        CFG_DEBOUNCE:     cfg_r.debounce_us     <= cfg_wdata;
        CFG_LONG_PRESS:   cfg_r.long_press_us   <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  // The sample moves on whenever the result register is free or emptying.
  assign step     = smp_vld_r && (!res_vld_r || out_ready);
  assign in_ready = !smp_vld_r || step;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_vld_r <= 1'b0;
    end else if (in_ready) begin
      smp_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      smp_r <= in_data;
    end
  end

  tbq_touch u_touch (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .sample (smp_r),
    .cfg    (cfg_r),
    .evt    (tevt)
  );

  tbq_button u_button (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .sample (smp_r),
    .cfg    (cfg_r),
    .action (act)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (step) begin
      res_vld_r <= 1'b1;
    end else if (out_ready) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r.touch_event   <= tevt.event_vld;
      res_r.event_x       <= tevt.x;
      res_r.event_y       <= tevt.y;
      res_r.event_down    <= tevt.down;
      res_r.event_time_us <= tevt.time_us;
      res_r.button_action <= act;
    end
  end

  assign out_valid = res_vld_r;
  assign out_data  = res_r;

endmodule

>>> hw/rtl/tbq_touch.sv
// ----------------------------------------------------------------------------
// tbq_touch: touch point tracker
// Keeps the last reported point and the release timer, and produces a
// touch-down event for a new or moved point and a touch-up event once the
// no-touch status has held for the release hold time.
// ----------------------------------------------------------------------------
module tbq_touch (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  tbq_pkg::in_item_t        sample,
  input  tbq_pkg::cfg_regs_t       cfg,
  output tbq_pkg::touch_evt_t      evt
);
  import tbq_pkg::*;

  logic [COORD_BITS-1:0] last_x_r, last_x_nxt;
  logic [COORD_BITS-1:0] last_y_r, last_y_nxt;
  logic                  touching_r, touching_nxt;
  logic                  pend_r, pend_nxt;
  logic [31:0]           rel_start_r, rel_start_nxt;
  logic [31:0]           elapsed;

  assign elapsed = sample.now_us - rel_start_r;

  // Next touch state and event for the current sample.
  always_comb begin
    last_x_nxt    = last_x_r;
    last_y_nxt    = last_y_r;
    touching_nxt  = touching_r;
    pend_nxt      = pend_r;
    rel_start_nxt = rel_start_r;
    evt           = '0;
    if (sample.touch_status == TS_POINT) begin
      pend_nxt = 1'b0;
      if (!touching_r || sample.touch_x != last_x_r || sample.touch_y != last_y_r) begin
        evt.event_vld = 1'b1;
        evt.x         = sample.touch_x;
        evt.y         = sample.touch_y;
        evt.down      = 1'b1;
        evt.time_us   = sample.now_us;
        last_x_nxt    = sample.touch_x;
        last_y_nxt    = sample.touch_y;
      end
      touching_nxt = 1'b1;
    end else if (sample.touch_status == TS_NONE && touching_r) begin
      if (!pend_r) begin
        pend_nxt      = 1'b1;
        rel_start_nxt = sample.now_us;
      end else if (elapsed >= cfg.release_hold_us) begin
        evt.event_vld = 1'b1;
        evt.x         = last_x_r;
        evt.y         = last_y_r;
        evt.down      = 1'b0;
        evt.time_us   = sample.now_us;
        touching_nxt  = 1'b0;
        pend_nxt      = 1'b0;
      end
    end
  end

  // State advances once per sample moved to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r    <= '0;
      last_y_r    <= '0;
      touching_r  <= 1'b0;
      pend_r      <= 1'b0;
      rel_start_r <= '0;
    end else if (step) begin
      last_x_r    <= last_x_nxt;
      last_y_r    <= last_y_nxt;
      touching_r  <= touching_nxt;
      pend_r      <= pend_nxt;
      rel_start_r <= rel_start_nxt;
    end
  end

endmodule

>>> hw/rtl/tbq_button.sv
// ----------------------------------------------------------------------------
// tbq_button: button debouncer and press qualifier
// Debounces the raw button level by time and turns debounced releases and
// long presses into start, stop and replay requests.
// ----------------------------------------------------------------------------
module tbq_button (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  tbq_pkg::in_item_t   sample,
  input  tbq_pkg::cfg_regs_t  cfg,
  output tbq_pkg::action_t    action
);
  import tbq_pkg::*;

  logic        raw_down_r, raw_down_nxt;
  logic [31:0] raw_chg_r, raw_chg_nxt;
  logic        btn_down_r, btn_down_nxt;
  logic [31:0] pressed_r, pressed_nxt;
  logic        lp_done_r, lp_done_nxt;
  logic [31:0] stable_time;
  logic [31:0] held_time;

  // Raw level tracking: restart the stability timer on every change.
  always_comb begin
    raw_down_nxt = ~sample.button_level;
    raw_chg_nxt  = (raw_down_nxt != raw_down_r) ? sample.now_us : raw_chg_r;
  end

  assign stable_time = sample.now_us - raw_chg_nxt;

  // Debounced edge handling, then the long-press check on the new state.
  always_comb begin
    btn_down_nxt = btn_down_r;
    pressed_nxt  = pressed_r;
    lp_done_nxt  = lp_done_r;
    action       = ACT_NONE;
    if (raw_down_nxt != btn_down_r && stable_time >= cfg.debounce_us) begin
      btn_down_nxt = raw_down_nxt;
      if (raw_down_nxt) begin
        pressed_nxt = sample.now_us;
        lp_done_nxt = 1'b0;
      end else if (sample.recording_active) begin
        action = ACT_STOP;
      end else if (!lp_done_r) begin
        action = ACT_START;
      end
    end
    held_time = sample.now_us - pressed_nxt;
    if (btn_down_nxt && !sample.recording_active && !lp_done_nxt &&
        held_time >= cfg.long_press_us) begin
      action      = ACT_REPLAY;
      lp_done_nxt = 1'b1;
    end
  end

  // State advances once per sample moved to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_down_r <= 1'b0;
      raw_chg_r  <= '0;
      btn_down_r <= 1'b0;
      pressed_r  <= '0;
      lp_done_r  <= 1'b0;
    end else if (step) begin
      raw_down_r <= raw_down_nxt;
      raw_chg_r  <= raw_chg_nxt;
      btn_down_r <= btn_down_nxt;
      pressed_r  <= pressed_nxt;
      lp_done_r  <= lp_done_nxt;
    end
  end

endmodule

>>> verif/tb_touch_and_button_qualifier_unit.sv
// ----------------------------------------------------------------------------
// tb_touch_and_button_qualifier_unit: self-checking bench for the qualifier
// Sends poll samples through the valid/ready input, predicts each result
// with a cycle-free model of the touch tracker and button debouncer, and
// compares every result transfer field by field. A directed sequence comes
// first, then random touch and button sequences under several register
// settings and handshake idling patterns.
// ----------------------------------------------------------------------------
module tb_touch_and_button_qualifier_unit;
  import tbq_pkg::*;

  // Failed-read status codes; the block treats both alike.
  localparam logic [1:0] TS_FAIL     = 2'd2;
  localparam logic [1:0] TS_FAIL_ALT = 2'd3;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int BLOCK_ITEMS     = 140;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  in_item_t                in_data;
  logic                    out_valid;
  logic                    out_ready;
  out_item_t               out_data;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  // Typed-in expectation that travels with a directed sample.
  logic      stim_has_exp;
  out_item_t stim_exp;

  // Idle percentages and the receiver hold-off request.
  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  bit          hold_off_req;
  int          hold_offs_done;

  // Predictor copy of the registers and of the block state.
  logic [31:0]           hold_us;
  logic [31:0]           deb_us;
  logic [31:0]           long_us;
  logic [COORD_BITS-1:0] last_x;
  logic [COORD_BITS-1:0] last_y;
  logic                  touching;
  logic                  rel_pending;
  logic [31:0]           rel_start;
  logic                  raw_down;
  logic [31:0]           raw_changed;
  logic                  btn_down;
  logic [31:0]           pressed_at;
  logic                  long_done;

  // Expected results, oldest first, and run statistics.
  out_item_t pending_results[$];
  out_item_t predicted;
  out_item_t want;
  int        err_count;
  int        samples_accepted;
  int        results_checked;
  int        touch_events_seen;
  int        actions_seen[4];
  int        settings_used;

  // Random sequence state that persists across blocks.
  logic [31:0]           clock_us;
  logic                  finger_on;
  logic [COORD_BITS-1:0] cur_x;
  logic [COORD_BITS-1:0] cur_y;
  logic                  btn_held;
  logic                  rec_on;

  // Directed sequence storage.
  in_item_t  dir_stim[$];
  bit        dir_typed[$];
  out_item_t dir_exp[$];

  touch_and_button_qualifier_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Clock generation.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Compute the result of one poll sample and advance the predictor state.
  function automatic out_item_t qualify_sample(input in_item_t s);
    out_item_t r;
    action_t   act;
    logic [31:0] dt;
    logic      raw_next;
    r = '0;
    act = ACT_NONE;
    // Touch tracking: a new or moved point reports down, a held no-touch
    // reports release at the last point, a failed read changes nothing.
    if (s.touch_status == TS_POINT) begin
      rel_pending = 1'b0;
      if (!touching || s.touch_x != last_x || s.touch_y != last_y) begin
        r.touch_event = 1'b1;
        r.event_x = s.touch_x;
        r.event_y = s.touch_y;
        r.event_down = 1'b1;
        r.event_time_us = s.now_us;
        last_x = s.touch_x;
        last_y = s.touch_y;
      end
      touching = 1'b1;
    end else if (s.touch_status == TS_NONE && touching) begin
      dt = s.now_us - rel_start;
      if (!rel_pending) begin
        rel_pending = 1'b1;
        rel_start = s.now_us;
      end else if (dt >= hold_us) begin
        r.touch_event = 1'b1;
        r.event_x = last_x;
        r.event_y = last_y;
        r.event_down = 1'b0;
        r.event_time_us = s.now_us;
        touching = 1'b0;
        rel_pending = 1'b0;
      end
    end
    // Button debounce by elapsed time since the last raw change.
    raw_next = !s.button_level;
    if (raw_next != raw_down) begin
      raw_down = raw_next;
      raw_changed = s.now_us;
    end
    dt = s.now_us - raw_changed;
    if (raw_down != btn_down && dt >= deb_us) begin
      btn_down = raw_down;
      if (btn_down) begin
        pressed_at = s.now_us;
        long_done = 1'b0;
      end else if (s.recording_active) begin
        act = ACT_STOP;
      end else if (!long_done) begin
        act = ACT_START;
      end
    end
    // Long press asks for replay once per press while not recording.
    dt = s.now_us - pressed_at;
    if (btn_down && !s.recording_active && !long_done && dt >= long_us) begin
      act = ACT_REPLAY;
      long_done = 1'b1;
    end
    r.button_action = act;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h",
               $time, name, exp_v, got_v);
      err_count++;
    end
  endtask

  // Monitor: tracks register writes, predicts accepted samples and checks
  // every result transfer against the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_us = RELEASE_HOLD_RST;
      deb_us = DEBOUNCE_RST;
      long_us = LONG_PRESS_RST;
      last_x = '0;
      last_y = '0;
      touching = 1'b0;
      rel_pending = 1'b0;
      rel_start = '0;
      raw_down = 1'b0;
      raw_changed = '0;
      btn_down = 1'b0;
      pressed_at = '0;
      long_done = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RELEASE_HOLD: hold_us = cfg_wdata;
          CFG_DEBOUNCE:     deb_us = cfg_wdata;
          CFG_LONG_PRESS:   long_us = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predicted = qualify_sample(in_data);
        pending_results.push_back(stim_has_exp ? stim_exp : predicted);
        samples_accepted++;
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %p", $time, out_data);
          err_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("touch_event", 32'(want.touch_event), 32'(out_data.touch_event));
          check_field("event_x", 32'(want.event_x), 32'(out_data.event_x));
          check_field("event_y", 32'(want.event_y), 32'(out_data.event_y));
          check_field("event_down", 32'(want.event_down), 32'(out_data.event_down));
          check_field("event_time_us", want.event_time_us, out_data.event_time_us);
          check_field("button_action", 32'(want.button_action),
                      32'(out_data.button_action));
          results_checked++;
          if (out_data.touch_event === 1'b1) touch_events_seen++;
          if (!$isunknown(out_data.button_action))
            actions_seen[out_data.button_action]++;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        for (int c = 0; c < HOLD_OFF_CYCLES; c++) @(posedge clk);
        hold_off_req = 1'b0;
        hold_offs_done++;
      end
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Offer one sample, with random idle cycles first, until it transfers.
  task automatic send_sample(input in_item_t s, input logic typed, input out_item_t e);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    stim_has_exp <= typed;
    stim_exp <= e;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // Stop offering and wait until every expected result has been seen.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all three registers on consecutive cycles; call only when idle.
  task automatic write_config(input logic [31:0] hold, input logic [31:0] deb,
                              input logic [31:0] lng);
    cfg_we <= 1'b1;
    cfg_index <= CFG_RELEASE_HOLD;
    cfg_wdata <= hold;
    @(posedge clk);
    cfg_index <= CFG_DEBOUNCE;
    cfg_wdata <= deb;
    @(posedge clk);
    cfg_index <= CFG_LONG_PRESS;
    cfg_wdata <= lng;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Append one directed row; typed rows carry their expected result.
  task automatic add_row(input logic [1:0] st, input logic [COORD_BITS-1:0] x,
                         input logic [COORD_BITS-1:0] y, input logic [31:0] t,
                         input logic lvl, input logic rec, input bit typed,
                         input logic ev, input logic dn, input action_t act);
    in_item_t  s;
    out_item_t e;
    s.touch_status = st;
    s.touch_x = x;
    s.touch_y = y;
    s.now_us = t;
    s.button_level = lvl;
    s.recording_active = rec;
    e = '0;
    if (ev) begin
      e.touch_event = 1'b1;
      e.event_x = x;
      e.event_y = y;
      e.event_down = dn;
      e.event_time_us = t;
    end
    e.button_action = act;
    dir_stim.push_back(s);
    dir_typed.push_back(typed);
    dir_exp.push_back(e);
  endtask

  // One block of random touch and button sequences.
  task automatic run_block(input int n_items, input int unsigned scale,
                           input bit pause_mid, input bit hold_mid);
    in_item_t s;
    int unsigned r;
    logic [31:0] step;
    for (int i = 0; i < n_items; i++) begin
      if (pause_mid && i == n_items / 2) drain_results();
      if (hold_mid && i == n_items / 3) hold_off_req = 1'b1;
      // Time mostly advances in steps around the register settings.
      r = $urandom_range(99);
      if (r < 4) step = '0;
      else if (r < 97) step = $urandom_range(scale);
      else step = $urandom();
      clock_us += step;
      // Finger goes down at a fresh point or lifts now and then.
      if ($urandom_range(99) < 12) begin
        finger_on = !finger_on;
        if (finger_on) begin
          cur_x = COORD_BITS'($urandom());
          cur_y = COORD_BITS'($urandom());
        end
      end
      r = $urandom_range(99);
      if (finger_on)
        s.touch_status = (r < 80) ? TS_POINT : (r < 90) ? TS_NONE :
                         ($urandom_range(1) ? TS_FAIL : TS_FAIL_ALT);
      else
        s.touch_status = (r < 85) ? TS_NONE : (r < 95) ?
                         ($urandom_range(1) ? TS_FAIL : TS_FAIL_ALT) : TS_POINT;
      if (s.touch_status == TS_POINT) begin
        r = $urandom_range(99);
        if (r >= 90) begin
          cur_x = COORD_BITS'($urandom());
          cur_y = COORD_BITS'($urandom());
        end else if (r >= 60) begin
          cur_x = cur_x + COORD_BITS'($urandom_range(6)) - COORD_BITS'(3);
          cur_y = cur_y + COORD_BITS'($urandom_range(6)) - COORD_BITS'(3);
        end
        s.touch_x = cur_x;
        s.touch_y = cur_y;
      end else begin
        // Coordinates are meaningless here; sometimes fill them with noise.
        s.touch_x = $urandom_range(1) ? cur_x : COORD_BITS'($urandom());
        s.touch_y = $urandom_range(1) ? cur_y : COORD_BITS'($urandom());
      end
      // Button presses and releases with occasional contact bounce.
      if ($urandom_range(99) < 6) btn_held = !btn_held;
      s.button_level = ($urandom_range(99) < 10) ? btn_held : !btn_held;
      if ($urandom_range(99) < 4) rec_on = !rec_on;
      s.recording_active = rec_on;
      s.now_us = clock_us;
      send_sample(s, 1'b0, '0);
    end
    drain_results();
  endtask

  // Run limit.
  initial begin
    #3000000;
    $display("tb_touch_and_button_qualifier_unit failed");
    $finish;
  end

  // Main sequence.
  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    stim_has_exp <= 1'b0;
    stim_exp <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_RELEASE_HOLD;
    cfg_wdata <= '0;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_off_req = 1'b0;
    hold_offs_done = 0;
    err_count = 0;
    samples_accepted = 0;
    results_checked = 0;
    touch_events_seen = 0;
    settings_used = 1;
    clock_us = 32'd2000000;
    finger_on = 1'b0;
    cur_x = '0;
    cur_y = '0;
    btn_held = 1'b0;
    rec_on = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows at the reset register values: touch down at the
    // coordinate extremes, same point, move, failed reads, release timing,
    // button debounce, long press, start and stop, and timestamp wrap.
    add_row(TS_NONE,     12'h000, 12'h000, 32'd0,      1, 0, 1, 0, 0, ACT_NONE);
    add_row(TS_POINT,    12'hfff, 12'hfff, 32'd100,    1, 0, 1, 1, 1, ACT_NONE);
    add_row(TS_POINT,    12'hfff, 12'hfff, 32'd200,    1, 0, 1, 0, 0, ACT_NONE);
    add_row(TS_POINT,    12'h000, 12'h000, 32'd300,    1, 0, 1, 1, 1, ACT_NONE);
    add_row(TS_FAIL,     12'habc, 12'h123, 32'd400,    1, 0, 1, 0, 0, ACT_NONE);
    add_row(TS_FAIL_ALT, 12'h543, 12'hedc, 32'd500,    1, 0, 1, 0, 0, ACT_NONE);
    add_row(TS_NONE,     12'h000, 12'h000, 32'd1000,   1, 0, 0, 0, 0, ACT_NONE);
    add_row(TS_NONE,     12'h000, 12'h000, 32'd5000,   1, 0, 0, 0, 0, ACT_NONE);
    add_row(TS_POINT,    12'h000, 12'h000, 32'd6000,   1, 0, 0, 0, 0, ACT_NONE);
    add_row(TS_NONE,     12'h000, 12'h000, 32'd7000,   1, 0, 0, 0, 0, ACT_NONE);
    add_row(TS_NONE,     12'h000, 12'h000, 32'd27000,  1, 0, 1, 1, 0, ACT_NONE);
    add_row(TS_NONE,     12'h000, 12'h000, 32'd40000,  0, 0, 0, 0, 0, ACT_NONE);
    add_row(TS_NONE,     12'h000, 12'h000, 32'd65000,  0, 0, 0, 0, 0, ACT_NONE);
    add_row(TS_NONE,     12'h000, 12'h000, 32'd100000, 1, 0, 0, 0, 0, ACT_NONE);
    add_row(TS_NONE,     12'h000, 12'h000, 32'd865000, 0, 0, 1, 0, 0, ACT_REPLAY);
    add_row(TS_NONE,     12'h000, 12'h000, 32'd900000, 1, 0, 0, 0, 0, ACT_NONE);
    add_row(TS_NONE,     12'h000, 12'h000, 32'd925000, 1, 0, 0, 0, 0, ACT_NONE);
    add_row(TS_NONE,     12'h000, 12'h000, 32'd930000, 0, 0, 0, 0, 0, ACT_NONE);
    add_row(TS_NONE,     12'h000, 12'h000, 32'd955000, 0, 0, 0, 0, 0, ACT_NONE);
    add_row(TS_NONE,     12'h000, 12'h000, 32'd990000, 1, 0, 0, 0, 0, ACT_NONE);
    add_row(TS_NONE,     12'h000, 12'h000, 32'd1015000, 1, 0, 1, 0, 0, ACT_START);
    add_row(TS_NONE,     12'h000, 12'h000, 32'd1020000, 0, 1, 0, 0, 0, ACT_NONE);
    add_row(TS_NONE,     12'h000, 12'h000, 32'd1045000, 0, 1, 0, 0, 0, ACT_NONE);
    add_row(TS_NONE,     12'h000, 12'h000, 32'd1050000, 1, 1, 0, 0, 0, ACT_NONE);
    add_row(TS_NONE,     12'h000, 12'h000, 32'd1075000, 1, 1, 1, 0, 0, ACT_STOP);
    add_row(TS_POINT,    12'h5a5, 12'ha5a, 32'hffff_f000, 1, 0, 0, 0, 0, ACT_NONE);
    add_row(TS_NONE,     12'h000, 12'h000, 32'hffff_f100, 1, 0, 0, 0, 0, ACT_NONE);
    add_row(TS_NONE,     12'h000, 12'h000, 32'd16160,  1, 0, 0, 0, 0, ACT_NONE);
    foreach (dir_stim[i]) send_sample(dir_stim[i], dir_typed[i], dir_exp[i]);
    drain_results();

    // Random blocks: sender idles lightly and receiver heavily, then the
    // reverse, then no idling; each block runs under its own settings.
    snd_idle_pct = 22;
    rcv_idle_pct = 67;
    write_config(32'd400, 32'd300, 32'd2500);
    run_block(BLOCK_ITEMS, 120, 1'b0, 1'b0);
    write_config(32'd0, 32'd0, 32'd0);
    run_block(BLOCK_ITEMS, 40, 1'b0, 1'b0);
    snd_idle_pct = 67;
    rcv_idle_pct = 22;
    write_config(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    run_block(BLOCK_ITEMS, 1000, 1'b1, 1'b0);
    write_config($urandom_range(3000, 200), $urandom_range(3000, 200),
                 $urandom_range(3000, 200));
    run_block(BLOCK_ITEMS, 500, 1'b0, 1'b0);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_config(32'd1, 32'd1, 32'd1);
    run_block(BLOCK_ITEMS, 3, 1'b0, 1'b1);
    write_config(RELEASE_HOLD_RST, DEBOUNCE_RST, LONG_PRESS_RST);
    run_block(BLOCK_ITEMS, 12000, 1'b0, 1'b0);

    // Let any stray result show up before the verdict.
    in_valid <= 1'b0;
    for (int w = 0; w < 5000 && pending_results.size() != 0; w++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      err_count++;
    end
    $display("Checked %0d results from %0d samples under %0d register settings.",
             results_checked, samples_accepted, settings_used);
    $display("Saw %0d touch events, %0d starts, %0d stops, %0d replays, %0d hold-offs.",
             touch_events_seen, actions_seen[ACT_START], actions_seen[ACT_STOP],
             actions_seen[ACT_REPLAY], hold_offs_done);
    if (err_count == 0) begin
      $display("tb_touch_and_button_qualifier_unit passed");
    end else begin
      $display("tb_touch_and_button_qualifier_unit failed");
    end
    $finish;
  end

endmodule
